@@ design/wbsb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbsb_pkg
// Shared constants, types, state codes and coefficient tables for the
// windowed block spectrum bins block.
// ----------------------------------------------------------------------------
package wbsb_pkg;

   localparam int BLOCK_LENGTH    = 32;
   localparam int INDEX_WIDTH     = $clog2(BLOCK_LENGTH);
   localparam int SAMPLE_WIDTH    = 16;
   localparam int BIN_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int COEF_WIDTH      = 16;
   localparam int SUM_WIDTH       = SAMPLE_WIDTH + INDEX_WIDTH;
   localparam int DIFF_WIDTH      = SUM_WIDTH + 1;
   localparam int PROD_WIDTH      = DIFF_WIDTH + COEF_WIDTH;
   localparam int Y_WIDTH         = DIFF_WIDTH + 1;
   localparam int TW_WIDTH        = Y_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH       = TW_WIDTH + INDEX_WIDTH;
   localparam int PART_WIDTH      = 28;
   localparam int SQ_WIDTH        = 2 * PART_WIDTH + 1;
   localparam int RES_WIDTH       = SQ_WIDTH + 1;
   localparam int ROOT_STEPS      = 29;
   localparam int ITER_WIDTH      = $clog2(ROOT_STEPS);
   localparam int MAG_WIDTH       = 23;
   localparam int DRAIN_CYCLES    = 6;
   localparam int DRAIN_WIDTH     = $clog2(DRAIN_CYCLES);
   localparam int WIN_DEN         = BLOCK_LENGTH - 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_BIN  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_BIN = CSR_INDEX_WIDTH'(1);

   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_ROUND,
      ST_SQUARE,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_OUTPUT
   } wbsb_state_type;

   typedef struct packed {
      logic                   sample_we;
      logic                   first_sample;
      logic                   block_start;
      logic [INDEX_WIDTH-1:0] index;
      logic                   read_en;
      logic                   round_en;
      logic                   square_en;
      logic                   bin_sel;
      logic                   root_load;
      logic                   root_step;
      logic                   out_load;
   } wbsb_cmd_type;

   typedef struct packed {
      logic root_last;
   } wbsb_status_type;

   typedef logic signed [COEF_WIDTH-1:0] coef_table_type [BLOCK_LENGTH];

   typedef struct packed {
      logic signed [63:0] c;
      logic signed [63:0] s;
   } trig_pair_type;

   // Cosine and sine in Q2.30 of a 32-bit turn fraction.
   function automatic trig_pair_type trig_q30(input longint phase);
      longint quad;
      longint r;
      longint a;
      longint a2;
      longint s;
      longint ts;
      longint c;
      longint tc;
      trig_pair_type res;
      quad = (phase >>> 30) & 64'sd3;
      r    = phase & (Q30_ONE - 64'sd1);
      a    = (r * HALF_PI_Q30) >>> 30;
      a2   = (a * a) / Q30_ONE;
      s    = a;
      ts   = a;
      c    = Q30_ONE;
      tc   = Q30_ONE;
      ts = -((ts * a2) / Q30_ONE) / 6;   tc = -((tc * a2) / Q30_ONE) / 2;
      s  = s + ts;                       c  = c + tc;
      ts = -((ts * a2) / Q30_ONE) / 20;  tc = -((tc * a2) / Q30_ONE) / 12;
      s  = s + ts;                       c  = c + tc;
      ts = -((ts * a2) / Q30_ONE) / 42;  tc = -((tc * a2) / Q30_ONE) / 30;
      s  = s + ts;                       c  = c + tc;
      ts = -((ts * a2) / Q30_ONE) / 72;  tc = -((tc * a2) / Q30_ONE) / 56;
      s  = s + ts;                       c  = c + tc;
      ts = -((ts * a2) / Q30_ONE) / 110; tc = -((tc * a2) / Q30_ONE) / 90;
      s  = s + ts;                       c  = c + tc;
      ts = -((ts * a2) / Q30_ONE) / 156; tc = -((tc * a2) / Q30_ONE) / 132;
      s  = s + ts;                       c  = c + tc;
      ts = -((ts * a2) / Q30_ONE) / 210; tc = -((tc * a2) / Q30_ONE) / 182;
      s  = s + ts;                       c  = c + tc;
      case (quad)
         64'sd0: begin res.c = c;  res.s = s;  end
         64'sd1: begin res.c = -s; res.s = c;  end
         64'sd2: begin res.c = -c; res.s = -s; end
         default: begin res.c = s; res.s = -c; end
      endcase
      return res;
   endfunction

   function automatic longint round_q15(input longint v);
      longint mag;
      longint q;
      mag = (v < 0) ? -v : v;
      q   = (mag + 64'sd16384) >>> 15;
      return (v < 0) ? -q : q;
   endfunction

   function automatic logic signed [COEF_WIDTH-1:0] sat_q15(input longint v);
      logic signed [COEF_WIDTH-1:0] res;
      if (v > 64'sd32767) begin
         res = 16'sh7fff;
      end else if (v < -64'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = COEF_WIDTH'(v);
      end
      return res;
   endfunction

   function automatic coef_table_type build_window();
      coef_table_type t;
      trig_pair_type  p;
      longint         phase;
      longint         w30;
      for (int n = 0; n < BLOCK_LENGTH; n++) begin
         phase = (longint'(n % WIN_DEN) <<< 32) / WIN_DEN;
         p     = trig_q30(phase);
         w30   = (64'sd54 * Q30_ONE - 64'sd46 * p.c) / 100;
         t[n]  = sat_q15(round_q15(w30));
      end
      return t;
   endfunction

   function automatic coef_table_type build_cos();
      coef_table_type t;
      trig_pair_type  p;
      longint         phase;
      for (int n = 0; n < BLOCK_LENGTH; n++) begin
         phase = (longint'(n % BLOCK_LENGTH) <<< 32) / BLOCK_LENGTH;
         p     = trig_q30(phase);
         t[n]  = sat_q15(round_q15(p.c));
      end
      return t;
   endfunction

   function automatic coef_table_type build_sin();
      coef_table_type t;
      trig_pair_type  p;
      longint         phase;
      for (int n = 0; n < BLOCK_LENGTH; n++) begin
         phase = (longint'(n % BLOCK_LENGTH) <<< 32) / BLOCK_LENGTH;
         p     = trig_q30(phase);
         t[n]  = sat_q15(round_q15(p.s));
      end
      return t;
   endfunction

   localparam coef_table_type WIN_TABLE = build_window();
   localparam coef_table_type COS_TABLE = build_cos();
   localparam coef_table_type SIN_TABLE = build_sin();

endpackage

@@ design/wbsb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbsb_ctrl
// Controller: counts samples, sequences the accumulation pass, the two
// square roots and the result hand-off.
// ----------------------------------------------------------------------------
module wbsb_ctrl
   import wbsb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output wbsb_cmd_type    cmd,
   input  wbsb_status_type status
);

   wbsb_state_type         state_ff, state_in;
   logic [INDEX_WIDTH-1:0] count_ff, count_in;
   logic [INDEX_WIDTH-1:0] run_ff, run_in;
   logic [DRAIN_WIDTH-1:0] drain_ff, drain_in;
   logic                   sel_ff, sel_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic                   last;
   logic                   out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign last     = (count_ff == INDEX_WIDTH'(BLOCK_LENGTH - 1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && last) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (run_ff == INDEX_WIDTH'(BLOCK_LENGTH - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_WIDTH'(DRAIN_CYCLES - 1)) state_in = ST_ROUND;
         end
         ST_ROUND:     state_in = ST_SQUARE;
         ST_SQUARE:    state_in = ST_ROOT_LOAD;
         ST_ROOT_LOAD: state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_last) state_in = sel_ff ? ST_OUTPUT : ST_SQUARE;
         end
         ST_OUTPUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd              = '0;
      cmd.sample_we    = accept;
      cmd.first_sample = (count_ff == '0);
      cmd.block_start  = accept && last;
      cmd.index        = (state_ff == ST_IDLE) ? count_ff : run_ff;
      cmd.bin_sel      = sel_ff;
      unique case (state_ff)
         ST_RUN:       cmd.read_en   = 1'b1;
         ST_ROUND:     cmd.round_en  = 1'b1;
         ST_SQUARE:    cmd.square_en = 1'b1;
         ST_ROOT_LOAD: cmd.root_load = 1'b1;
         ST_ROOT:      cmd.root_step = 1'b1;
         ST_OUTPUT:    cmd.out_load  = out_free;
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept) count_in = last ? '0 : count_ff + 1'b1;
      run_in   = (state_ff == ST_RUN) ? run_ff + 1'b1 : '0;
      drain_in = (state_ff == ST_DRAIN) ? drain_ff + 1'b1 : '0;
      sel_in   = sel_ff;
      if (state_ff == ST_ROUND) begin
         sel_in = 1'b0;
      end else if ((state_ff == ST_ROOT) && status.root_last) begin
         sel_in = 1'b1;
      end
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         run_ff       <= '0;
         drain_ff     <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_ff       <= run_in;
         drain_ff     <= drain_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/wbsb_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbsb_datapath
// Datapath: sample buffer, running sum, windowing and twiddle pipeline,
// bin accumulators, shared bit-serial square root and result registers.
// ----------------------------------------------------------------------------
module wbsb_datapath
   import wbsb_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  wbsb_cmd_type                   cmd,
   output wbsb_status_type                status,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [BIN_WIDTH-1:0]           csr_write_data,
   output logic [MAG_WIDTH-1:0]           rsp_first_magnitude,
   output logic                           rsp_first_valid,
   output logic [MAG_WIDTH-1:0]           rsp_second_magnitude,
   output logic                           rsp_second_valid
);

   function automatic logic [PART_WIDTH-1:0] round_part(
      input logic signed [ACC_WIDTH-1:0] a);
      logic [ACC_WIDTH:0]  mag;
      logic [ACC_WIDTH:0]  q;
      logic [PART_WIDTH-1:0] res;
      mag = a[ACC_WIDTH-1] ? (ACC_WIDTH+1)'(-a) : (ACC_WIDTH+1)'(a);
      q   = (mag + (ACC_WIDTH+1)'(32768)) >> 16;
      if (q > (ACC_WIDTH+1)'(1 << 27)) begin
         res = PART_WIDTH'(1 << 27);
      end else begin
         res = q[PART_WIDTH-1:0];
      end
      return res;
   endfunction

   function automatic logic [MAG_WIDTH-1:0] sat_mag(input logic [RES_WIDTH-1:0] root);
      logic [RES_WIDTH-1:0] t;
      logic [MAG_WIDTH-1:0] res;
      t = (root + RES_WIDTH'(8)) >> 4;
      if (t > RES_WIDTH'({MAG_WIDTH{1'b1}})) begin
         res = {MAG_WIDTH{1'b1}};
      end else begin
         res = t[MAG_WIDTH-1:0];
      end
      return res;
   endfunction

   logic signed [SAMPLE_WIDTH-1:0] mem_ff [BLOCK_LENGTH];
   logic signed [SAMPLE_WIDTH-1:0] mem_q_ff;

   logic [BIN_WIDTH-1:0]          first_bin_ff, first_bin_in;
   logic [BIN_WIDTH-1:0]          second_bin_ff, second_bin_in;
   logic signed [SUM_WIDTH-1:0]   sum_ff, sum_in;

   logic                          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [INDEX_WIDTH-1:0]        n1_ff, n2_ff, n3_ff;
   logic signed [DIFF_WIDTH-1:0]  diff_ff, diff_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic [PROD_WIDTH-1:0]         prod_mag;
   logic [PROD_WIDTH-1:0]         y_mag;
   logic signed [Y_WIDTH-1:0]     y_ff, y_in;
   logic [INDEX_WIDTH+BIN_WIDTH-1:0] m1_full, m2_full;
   logic [INDEX_WIDTH-1:0]        m1_ff, m2_ff;
   logic signed [TW_WIDTH-1:0]    pc1_ff, ps1_ff, pc2_ff, ps2_ff;
   logic signed [ACC_WIDTH-1:0]   re1_ff, im1_ff, re2_ff, im2_ff;
   logic signed [ACC_WIDTH-1:0]   re1_in, im1_in, re2_in, im2_in;

   logic [PART_WIDTH-1:0]         pre1_ff, pim1_ff, pre2_ff, pim2_ff;
   logic [PART_WIDTH-1:0]         sq_re_op, sq_im_op;
   logic [2*PART_WIDTH-1:0]       sq_re_ff, sq_im_ff;
   logic [SQ_WIDTH-1:0]           rem_ff, rem_in;
   logic [RES_WIDTH-1:0]          res_ff, res_in;
   logic [RES_WIDTH-1:0]          bit_ff, bit_in;
   logic [RES_WIDTH-1:0]          trial;
   logic [ITER_WIDTH-1:0]         iter_ff, iter_in;
   logic [RES_WIDTH-1:0]          root0_ff;

   logic [MAG_WIDTH-1:0]          first_mag_ff, second_mag_ff;
   logic                          first_valid_ff, second_valid_ff;
   logic                          first_ok, second_ok;

   always_ff @(posedge clock) begin
      if (cmd.sample_we) mem_ff[cmd.index] <= req_sample;
      mem_q_ff <= mem_ff[cmd.index];
   end

   always_comb begin
      first_bin_in  = first_bin_ff;
      second_bin_in = second_bin_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIRST_BIN:  first_bin_in  = csr_write_data;
            CSR_SECOND_BIN: second_bin_in = csr_write_data;
            default: ;
         endcase
      end
      sum_in = sum_ff;
      if (cmd.sample_we) begin
         sum_in = cmd.first_sample ? SUM_WIDTH'(req_sample)
                                   : sum_ff + SUM_WIDTH'(req_sample);
      end
   end

   always_comb begin
      diff_in  = (DIFF_WIDTH'(mem_q_ff) <<< INDEX_WIDTH) - DIFF_WIDTH'(sum_ff);
      prod_in  = diff_ff * WIN_TABLE[n2_ff];
      prod_mag = prod_ff[PROD_WIDTH-1] ? PROD_WIDTH'(-prod_ff) : PROD_WIDTH'(prod_ff);
      y_mag    = (prod_mag + PROD_WIDTH'(16384)) >> 15;
      y_in     = prod_ff[PROD_WIDTH-1] ? -Y_WIDTH'(y_mag) : Y_WIDTH'(y_mag);
      m1_full  = first_bin_ff * n3_ff;
      m2_full  = second_bin_ff * n3_ff;
      re1_in   = re1_ff;
      im1_in   = im1_ff;
      re2_in   = re2_ff;
      im2_in   = im2_ff;
      if (cmd.block_start) begin
         re1_in = '0;
         im1_in = '0;
         re2_in = '0;
         im2_in = '0;
      end else if (v5_ff) begin
         re1_in = re1_ff + ACC_WIDTH'(pc1_ff);
         im1_in = im1_ff + ACC_WIDTH'(ps1_ff);
         re2_in = re2_ff + ACC_WIDTH'(pc2_ff);
         im2_in = im2_ff + ACC_WIDTH'(ps2_ff);
      end
   end

   always_comb begin
      sq_re_op = cmd.bin_sel ? pre2_ff : pre1_ff;
      sq_im_op = cmd.bin_sel ? pim2_ff : pim1_ff;
      trial    = res_ff + bit_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      iter_in  = iter_ff;
      if (cmd.root_load) begin
         rem_in  = SQ_WIDTH'(sq_re_ff) + SQ_WIDTH'(sq_im_ff);
         res_in  = '0;
         bit_in  = RES_WIDTH'(1) << (2 * (ROOT_STEPS - 1));
         iter_in = ITER_WIDTH'(ROOT_STEPS - 1);
      end else if (cmd.root_step) begin
         if (RES_WIDTH'(rem_ff) >= trial) begin
            rem_in = rem_ff - trial[SQ_WIDTH-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         iter_in = iter_ff - 1'b1;
      end
   end

   assign first_ok  = (first_bin_ff < BIN_WIDTH'(BLOCK_LENGTH / 2));
   assign second_ok = (second_bin_ff < BIN_WIDTH'(BLOCK_LENGTH / 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         first_bin_ff  <= BIN_WIDTH'(2);
         second_bin_ff <= BIN_WIDTH'(4);
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
         iter_ff       <= '0;
      end else begin
         first_bin_ff  <= first_bin_in;
         second_bin_ff <= second_bin_in;
         v1_ff         <= cmd.read_en;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         v5_ff         <= v4_ff;
         iter_ff       <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      n1_ff   <= cmd.index;
      n2_ff   <= n1_ff;
      n3_ff   <= n2_ff;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      y_ff    <= y_in;
      m1_ff   <= m1_full[INDEX_WIDTH-1:0];
      m2_ff   <= m2_full[INDEX_WIDTH-1:0];
      pc1_ff  <= y_ff * COS_TABLE[m1_ff];
      ps1_ff  <= y_ff * SIN_TABLE[m1_ff];
      pc2_ff  <= y_ff * COS_TABLE[m2_ff];
      ps2_ff  <= y_ff * SIN_TABLE[m2_ff];
      re1_ff  <= re1_in;
      im1_ff  <= im1_in;
      re2_ff  <= re2_in;
      im2_ff  <= im2_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      if (cmd.round_en) begin
         pre1_ff <= round_part(re1_ff);
         pim1_ff <= round_part(im1_ff);
         pre2_ff <= round_part(re2_ff);
         pim2_ff <= round_part(im2_ff);
      end
      if (cmd.square_en) begin
         sq_re_ff <= sq_re_op * sq_re_op;
         sq_im_ff <= sq_im_op * sq_im_op;
         if (cmd.bin_sel) root0_ff <= res_ff;
      end
      if (cmd.out_load) begin
         first_mag_ff    <= first_ok ? sat_mag(root0_ff) : '0;
         first_valid_ff  <= first_ok;
         second_mag_ff   <= second_ok ? sat_mag(res_ff) : '0;
         second_valid_ff <= second_ok;
      end
   end

   assign status.root_last     = (iter_ff == '0);
   assign rsp_first_magnitude  = first_mag_ff;
   assign rsp_first_valid      = first_valid_ff;
   assign rsp_second_magnitude = second_mag_ff;
   assign rsp_second_valid     = second_valid_ff;

endmodule

@@ design/windowed_block_spectrum_bins.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_block_spectrum_bins
// Hamming-windowed DFT magnitudes at two programmable bins of a 32-sample
// block.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while req_stall is low and produce no
// response until the 32nd of a block. That request starts a pass with
// req_stall high: the buffer streams through one windowing and twiddle
// pipeline that serves both bins, the pipeline drains, and a shared
// bit-serial square root handles each bin in turn. A finished response waits
// in an output register, so sample requests are taken while it is still stalled.
module windowed_block_spectrum_bins
   import wbsb_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [MAG_WIDTH-1:0]           rsp_first_magnitude,
   output logic                           rsp_first_valid,
   output logic [MAG_WIDTH-1:0]           rsp_second_magnitude,
   output logic                           rsp_second_valid,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [BIN_WIDTH-1:0]           csr_write_data
);

   wbsb_cmd_type    cmd;
   wbsb_status_type status;

   wbsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   wbsb_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_sample           (req_sample),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_first_magnitude  (rsp_first_magnitude),
      .rsp_first_valid      (rsp_first_valid),
      .rsp_second_magnitude (rsp_second_magnitude),
      .rsp_second_valid     (rsp_second_valid)
   );

endmodule

@@ tb/wbsb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbsb_checker
// Watches the sample, response and register ports of the windowed block
// spectrum bins block. It keeps its own sample buffer and bin settings,
// predicts the two windowed DFT magnitudes of every completed block and
// compares each response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module wbsb_checker
   import wbsb_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [MAG_WIDTH-1:0]           rsp_first_magnitude,
   input  logic                           rsp_first_valid,
   input  logic [MAG_WIDTH-1:0]           rsp_second_magnitude,
   input  logic                           rsp_second_valid,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [BIN_WIDTH-1:0]           csr_write_data,
   output int                             failures,
   output int                             pending,
   output int                             checked
);

   typedef struct {
      logic [MAG_WIDTH-1:0] first_mag;
      logic                 first_ok;
      logic [MAG_WIDTH-1:0] second_mag;
      logic                 second_ok;
   } bin_pair_type;

   localparam longint ONE_Q30 = 64'sd1 << 30;

   longint       window_q15 [BLOCK_LENGTH];
   longint       cos_q15 [BLOCK_LENGTH];
   longint       sin_q15 [BLOCK_LENGTH];
   longint       block_samples [BLOCK_LENGTH];
   int           fill_count;
   logic [BIN_WIDTH-1:0] bin_a;
   logic [BIN_WIDTH-1:0] bin_b;
   bin_pair_type spectra_due [$];

   function automatic longint div_nearest(input longint num, input longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q   = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clamp_q15(input longint v);
      return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
   endfunction

   // Cosine and sine of 2*pi*num/den in Q2.30, by quadrant and Taylor series.
   task automatic angle_q30(input longint num, input longint den,
                            output longint cv, output longint sv);
      longint turn;
      longint quadrant;
      longint a;
      longint a2;
      longint s;
      longint ts;
      longint c;
      longint tc;
      turn     = ((num % den) << 32) / den;
      quadrant = (turn >> 30) & 3;
      a        = ((turn & (ONE_Q30 - 1)) * 64'sd1686629713) >>> 30;
      a2       = (a * a) / ONE_Q30;
      s = a; ts = a; c = ONE_Q30; tc = ONE_Q30;
      for (longint k = 1; k < 8; k++) begin
         ts = -((ts * a2) / ONE_Q30) / ((2 * k) * (2 * k + 1));
         tc = -((tc * a2) / ONE_Q30) / ((2 * k - 1) * (2 * k));
         s  = s + ts;
         c  = c + tc;
      end
      case (quadrant)
         0: begin cv = c;  sv = s;  end
         1: begin cv = -s; sv = c;  end
         2: begin cv = -c; sv = -s; end
         default: begin cv = s; sv = -c; end
      endcase
   endtask

   function automatic longint int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bit_w;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= root + bit_w) begin
            v    = v - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return longint'(root);
   endfunction

   function automatic logic [MAG_WIDTH-1:0] magnitude_at(input longint y [BLOCK_LENGTH],
                                                         input int bin);
      longint re;
      longint im;
      longint rq;
      longint iq;
      longint mag;
      re = 0;
      im = 0;
      for (int n = 0; n < BLOCK_LENGTH; n++) begin
         re += y[n] * cos_q15[(bin * n) % BLOCK_LENGTH];
         im += y[n] * sin_q15[(bin * n) % BLOCK_LENGTH];
      end
      rq = div_nearest(re * 16, 64'sd32768 * BLOCK_LENGTH);
      iq = div_nearest(im * 16, 64'sd32768 * BLOCK_LENGTH);
      rq = (rq < 0) ? -rq : rq;
      iq = (iq < 0) ? -iq : iq;
      if (rq > (64'sd1 << 27)) rq = 64'sd1 << 27;
      if (iq > (64'sd1 << 27)) iq = 64'sd1 << 27;
      mag = (int_sqrt(rq * rq + iq * iq) + 8) >> 4;
      return (mag > 8388607) ? MAG_WIDTH'(8388607) : MAG_WIDTH'(mag);
   endfunction

   function automatic bin_pair_type block_spectrum();
      longint       total;
      longint       y [BLOCK_LENGTH];
      bin_pair_type res;
      total = 0;
      for (int n = 0; n < BLOCK_LENGTH; n++) total += block_samples[n];
      for (int n = 0; n < BLOCK_LENGTH; n++) begin
         y[n] = div_nearest((BLOCK_LENGTH * block_samples[n] - total) * window_q15[n],
                            64'sd32768);
      end
      res.first_ok   = (bin_a < BLOCK_LENGTH / 2);
      res.first_mag  = res.first_ok ? magnitude_at(y, bin_a) : '0;
      res.second_ok  = (bin_b < BLOCK_LENGTH / 2);
      res.second_mag = res.second_ok ? magnitude_at(y, bin_b) : '0;
      return res;
   endfunction

   initial begin
      longint cv;
      longint sv;
      for (int n = 0; n < BLOCK_LENGTH; n++) begin
         angle_q30(n, BLOCK_LENGTH - 1, cv, sv);
         window_q15[n] = clamp_q15(div_nearest((54 * ONE_Q30 - 46 * cv) / 100, 32768));
         angle_q30(n, BLOCK_LENGTH, cv, sv);
         cos_q15[n] = clamp_q15(div_nearest(cv, 32768));
         sin_q15[n] = clamp_q15(div_nearest(sv, 32768));
      end
      failures = 0;
      checked  = 0;
   end

   assign pending = spectra_due.size();

   always @(posedge clock) begin
      bin_pair_type due;
      if (reset) begin
         fill_count = 0;
         bin_a      = BIN_WIDTH'(2);
         bin_b      = BIN_WIDTH'(4);
         spectra_due.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_FIRST_BIN) bin_a = csr_write_data;
            else if (csr_index == CSR_SECOND_BIN) bin_b = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            block_samples[fill_count] = longint'(req_sample);
            fill_count++;
            if (fill_count == BLOCK_LENGTH) begin
               fill_count = 0;
               spectra_due.push_back(block_spectrum());
            end
         end
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (spectra_due.size() == 0) begin
               failures++;
               $display("%t: response with none expected: %0d/%0d %0d/%0d", $time,
                        rsp_first_magnitude, rsp_first_valid,
                        rsp_second_magnitude, rsp_second_valid);
            end else begin
               due = spectra_due.pop_front();
               if (rsp_first_magnitude !== due.first_mag) begin
                  failures++;
                  $display("%t: first_magnitude expected %0d actual %0d", $time,
                           due.first_mag, rsp_first_magnitude);
               end
               if (rsp_first_valid !== due.first_ok) begin
                  failures++;
                  $display("%t: first_valid expected %0d actual %0d", $time,
                           due.first_ok, rsp_first_valid);
               end
               if (rsp_second_magnitude !== due.second_mag) begin
                  failures++;
                  $display("%t: second_magnitude expected %0d actual %0d", $time,
                           due.second_mag, rsp_second_magnitude);
               end
               if (rsp_second_valid !== due.second_ok) begin
                  failures++;
                  $display("%t: second_valid expected %0d actual %0d", $time,
                           due.second_ok, rsp_second_valid);
               end
            end
         end
      end
   end

endmodule

@@ tb/tb_windowed_block_spectrum_bins.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_block_spectrum_bins
// Drives sample blocks of tones, extremes, steps and random noise into the
// spectrum bins block under several bin settings and idling mixes, including
// a long response hold-off, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_windowed_block_spectrum_bins;
   import wbsb_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [MAG_WIDTH-1:0]           rsp_first_magnitude;
   logic                           rsp_first_valid;
   logic [MAG_WIDTH-1:0]           rsp_second_magnitude;
   logic                           rsp_second_valid;
   logic                           csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index;
   logic [BIN_WIDTH-1:0]           csr_write_data;
   int                             failures;
   int                             pending;
   int                             checked;
   int                             send_idle_pct;
   int                             stall_pct;
   int                             hold_cycles;
   int                             cycle_count;
   int                             blocks_sent;

   windowed_block_spectrum_bins DUT (.*);

   wbsb_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response back-pressure: random stalling, or a long hold-off when asked.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_sample(input int value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= SAMPLE_WIDTH'(value);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_block(input int kind);
      int    amp;
      int    bin;
      real   ph;
      int    v;
      amp = $urandom_range(0, 32767);
      bin = $urandom_range(0, 31);
      ph  = $urandom_range(0, 999) / 159.0;
      for (int n = 0; n < BLOCK_LENGTH; n++) begin
         case (kind)
            0: v = $urandom_range(0, 65535) - 32768;
            1: v = (n % 2) ? 32767 : -32768;
            2: v = int'(amp * $cos(6.283185307 * bin * n / BLOCK_LENGTH + ph));
            3: v = (n < bin) ? 32767 : -32768;
            4: v = (n == bin) ? amp : 0;
            5: v = $urandom_range(0, 15) - 8;
            default: v = (kind == 6) ? 32767 : -32768;
         endcase
         send_sample(v);
      end
      blocks_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_bins(input int a, input int b);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FIRST_BIN;
      csr_write_data   <= BIN_WIDTH'(a);
      @(posedge clock);
      csr_index        <= CSR_SECOND_BIN;
      csr_write_data   <= BIN_WIDTH'(b);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int idle_mix [4][2];
      idle_mix = '{'{0, 0}, '{51, 0}, '{0, 51}, '{21, 21}};
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_sample       <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_FIRST_BIN;
      csr_write_data   <= '0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      hold_cycles      = 0;
      cycle_count      = 0;
      blocks_sent      = 0;
      rsp_stall        <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 8; k++) send_block(k);
      settle();
      write_bins(0, 31);
      for (int k = 0; k < 8; k++) send_block(k);
      settle();
      write_bins(15, 16);
      for (int k = 0; k < 4; k++) send_block(k);

      for (int p = 0; p < 8; p++) begin
         settle();
         send_idle_pct = idle_mix[p % 4][0];
         stall_pct     = idle_mix[p % 4][1];
         case (p)
            0: write_bins(31, 0);
            1: write_bins(1, 14);
            2: write_bins(16, 15);
            default: write_bins($urandom_range(0, 31), $urandom_range(0, 15));
         endcase
         if (p == 5) hold_cycles = 800;
         for (int b = 0; b < 2; b++) send_block($urandom_range(0, 7));
         send_block(0);
      end
      settle();
      send_idle_pct = 21;
      stall_pct     = 21;
      write_bins(2, 4);
      for (int b = 0; b < 3; b++) send_block($urandom_range(0, 3) == 0 ? 5 : 2);
      settle();

      $display("Sent %0d sample blocks under varied bin settings and idling mixes;",
               blocks_sent);
      $display("%0d spectrum responses were compared.", checked);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
